FILE: design/mblb_pkg.sv
package mblb_pkg;

   localparam int MaxWords       = 64;
   localparam int SoloCost       = 500;
   localparam int LenW           = 7;
   localparam int LineW          = 8;
   localparam int CostW          = 23;
   localparam int TotalW         = 22;
   localparam int LineWidthReset = 80;
   localparam int ReqDataW       = 8;
   localparam int RspDataW       = 56;

   typedef struct packed {
      logic load;
      logic start;
      logic row_init;
      logic eval;
      logic mul1;
      logic mul2;
      logic cmp;
      logic wr;
      logic elat;
      logic eload;
      logic enext;
   } dp_cmd_type;

   typedef struct packed {
      logic k_is_one;
      logic fit;
      logic more;
      logic i_zero;
      logic div_done;
      logic last_line;
   } dp_status_type;

endpackage

FILE: design/mblb_ram.sv
module mblb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/mblb_div.sv
module mblb_div #(
   parameter int DW = 8,
   parameter int VW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder,
   output logic          done
);

   localparam int NW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          ge;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = NW'(DW);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DW-2:0], ge};
         rem_in  = ge ? diff[VW-1:0] : shifted[VW-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == NW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: design/mblb_dp.sv
module mblb_dp #(
   parameter int MAX_WORDS = mblb_pkg::MaxWords
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mblb_pkg::dp_cmd_type              cmd,
   output mblb_pkg::dp_status_type           status,
   input  logic [mblb_pkg::LenW-1:0]         word_length,
   input  logic [mblb_pkg::LineW-1:0]        line_width,
   output logic [mblb_pkg::RspDataW-1:0]     rsp_data,
   output logic                              rsp_last
);

   import mblb_pkg::*;

   localparam int AW = $clog2(MAX_WORDS);
   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam int GW = AW;

   logic [CW-1:0]     wl_ff, wl_in, n_ff, n_in, k_ff, k_in, pos_ff, pos_in;
   logic [CW-1:0]     bcnt_ff, bcnt_in, ecnt_ff, ecnt_in;
   logic [AW-1:0]     i_ff, i_in;
   logic              ovf_ff, ovf_in;
   logic [8:0]        used_ff, used_in;
   logic [CostW-1:0]  best_ff, best_in, costk_ff, costk_in, total_ff, total_in;
   logic [LineW-1:0]  bslack_ff, bslack_in, slack_ff, slack_in;
   logic [GW-1:0]     gaps_ff, gaps_in;
   logic [15:0]       q2_ff, q2_in;
   logic [8+GW:0]     tr_ff, tr_in;
   logic [TotalW-1:0] bad_ff, bad_in;
   logic [RspDataW-1:0] rsp_ff, rsp_in;
   logic              last_ff, last_in;

   logic [CW-1:0]     ik_sum, wl_next, eg;
   logic [LenW-1:0]   len_q;
   logic [CostW-1:0]  cost_q, cost_rd;
   logic [CW-1:0]     cnt_q;
   logic [LineW-1:0]  slack_q;
   logic [8:0]        used_new;
   logic [LineW-1:0]  slack_new;
   logic [CostW:0]    cand;
   logic              div_start;
   logic [LineW-1:0]  div_dvd, div_q;
   logic [GW-1:0]     div_dvs, div_r;
   logic              div_done;
   logic              len_we;
   logic [5:0]        o_first, o_ngc;
   logic [6:0]        o_cnt;
   logic [7:0]        o_ng;

   assign ik_sum    = CW'(i_ff) + k_ff;
   assign cost_rd   = (ik_sum == n_ff) ? '0 : cost_q;
   assign used_new  = used_ff + 9'(len_q) + 9'd1;
   assign slack_new = LineW'(9'(line_width) - used_new);
   assign len_we    = cmd.load && (wl_ff < CW'(MAX_WORDS));
   assign wl_next   = len_we ? wl_ff + 1'b1 : wl_ff;
   assign cand      = {1'b0, costk_ff} + (CostW + 1)'(bad_ff);
   assign eg        = ecnt_ff - 1'b1;

   assign div_start = cmd.eval | cmd.elat;
   assign div_dvd   = cmd.eval ? slack_new : slack_q;
   assign div_dvs   = cmd.eval ? GW'(k_ff - 1'b1)
                    : ((cnt_q > CW'(1)) ? GW'(cnt_q - 1'b1) : GW'(1));

   mblb_ram #(.WIDTH(LenW), .DEPTH(MAX_WORDS)) u_len_ram (
      .clock(clock), .we(len_we), .waddr(wl_ff[AW-1:0]), .wdata(word_length),
      .raddr(AW'(ik_sum - 1'b1)), .rdata(len_q)
   );

   mblb_ram #(.WIDTH(CostW), .DEPTH(MAX_WORDS)) u_cost_ram (
      .clock(clock), .we(cmd.wr), .waddr(i_ff), .wdata(best_ff),
      .raddr(AW'(ik_sum)), .rdata(cost_q)
   );

   mblb_ram #(.WIDTH(CW), .DEPTH(MAX_WORDS)) u_count_ram (
      .clock(clock), .we(cmd.wr), .waddr(i_ff), .wdata(bcnt_ff),
      .raddr(AW'(pos_ff)), .rdata(cnt_q)
   );

   mblb_ram #(.WIDTH(LineW), .DEPTH(MAX_WORDS)) u_slack_ram (
      .clock(clock), .we(cmd.wr), .waddr(i_ff), .wdata(bslack_ff),
      .raddr(AW'(pos_ff)), .rdata(slack_q)
   );

   mblb_div #(.DW(LineW), .VW(GW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .quotient(div_q), .remainder(div_r), .done(div_done)
   );

   always_comb begin
      wl_in     = wl_ff;
      ovf_in    = ovf_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      used_in   = used_ff;
      best_in   = best_ff;
      bcnt_in   = bcnt_ff;
      bslack_in = bslack_ff;
      costk_in  = costk_ff;
      slack_in  = slack_ff;
      gaps_in   = gaps_ff;
      q2_in     = q2_ff;
      tr_in     = tr_ff;
      bad_in    = bad_ff;
      total_in  = total_ff;
      ecnt_in   = ecnt_ff;
      rsp_in    = rsp_ff;
      last_in   = last_ff;
      o_first   = 6'(pos_ff);
      o_cnt     = 7'(ecnt_ff);
      o_ng      = '0;
      o_ngc     = '0;
      if (cmd.load) begin
         wl_in = wl_next;
         if (!len_we) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.start) begin
         n_in = wl_next;
         i_in = AW'(wl_next - 1'b1);
         k_in = CW'(1);
      end
      if (cmd.row_init) begin
         best_in   = cost_rd + CostW'(SoloCost);
         bcnt_in   = CW'(1);
         bslack_in = '0;
         used_in   = 9'(len_q);
         k_in      = k_ff + 1'b1;
      end
      if (cmd.eval) begin
         used_in  = used_new;
         slack_in = slack_new;
         costk_in = cost_rd;
         gaps_in  = GW'(k_ff - 1'b1);
      end
      if (cmd.mul1) begin
         q2_in = 16'(div_q) * 16'(div_q);
         tr_in = (9 + GW)'({div_q, 1'b1}) * (9 + GW)'(div_r);
      end
      if (cmd.mul2) begin
         bad_in = TotalW'(q2_ff * TotalW'(gaps_ff)) + TotalW'(tr_ff);
      end
      if (cmd.cmp) begin
         if (cand <= (CostW + 1)'(best_ff)) begin
            best_in   = cand[CostW-1:0];
            bcnt_in   = k_ff;
            bslack_in = slack_ff;
         end
         k_in = k_ff + 1'b1;
      end
      if (cmd.wr) begin
         if (i_ff == '0) begin
            total_in = best_ff;
            pos_in   = '0;
         end else begin
            i_in = i_ff - 1'b1;
            k_in = CW'(1);
         end
      end
      if (cmd.elat) begin
         ecnt_in = cnt_q;
      end
      if (cmd.eload) begin
         if (ecnt_ff > CW'(1)) begin
            o_ng  = div_q + 8'd1;
            o_ngc = 6'(eg - CW'(div_r));
         end
         rsp_in  = {6'd0, ovf_ff, total_ff[TotalW-1:0], o_ngc, o_ng, o_cnt, o_first};
         last_in = (pos_ff + ecnt_ff) >= n_ff;
      end
      if (cmd.enext) begin
         pos_in = pos_ff + ecnt_ff;
         if (last_ff) begin
            wl_in  = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff  <= '0;
         ovf_ff <= 1'b0;
      end else begin
         wl_ff  <= wl_in;
         ovf_ff <= ovf_in;
      end
      n_ff      <= n_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      pos_ff    <= pos_in;
      used_ff   <= used_in;
      best_ff   <= best_in;
      bcnt_ff   <= bcnt_in;
      bslack_ff <= bslack_in;
      costk_ff  <= costk_in;
      slack_ff  <= slack_in;
      gaps_ff   <= gaps_in;
      q2_ff     <= q2_in;
      tr_ff     <= tr_in;
      bad_ff    <= bad_in;
      total_ff  <= total_in;
      ecnt_ff   <= ecnt_in;
      rsp_ff    <= rsp_in;
      last_ff   <= last_in;
   end

   assign status.k_is_one  = (k_ff == CW'(1));
   assign status.fit       = used_new <= 9'(line_width);
   assign status.more      = ik_sum < n_ff;
   assign status.i_zero    = (i_ff == '0);
   assign status.div_done  = div_done;
   assign status.last_line = last_ff;

   assign rsp_data = rsp_ff;
   assign rsp_last = last_ff;

endmodule

FILE: design/mblb_ctrl.sv
module mblb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  mblb_pkg::dp_status_type status,
   output mblb_pkg::dp_cmd_type    cmd
);

   import mblb_pkg::*;

   typedef enum logic [11:0] {
      S_LOAD  = 12'b0000_0000_0001,
      S_RD    = 12'b0000_0000_0010,
      S_EVAL  = 12'b0000_0000_0100,
      S_DIV   = 12'b0000_0000_1000,
      S_MUL1  = 12'b0000_0001_0000,
      S_MUL2  = 12'b0000_0010_0000,
      S_CMP   = 12'b0000_0100_0000,
      S_WR    = 12'b0000_1000_0000,
      S_ERD   = 12'b0001_0000_0000,
      S_ELAT  = 12'b0010_0000_0000,
      S_EWAIT = 12'b0100_0000_0000,
      S_EOUT  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_EOUT);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            cmd.load  = accept;
            cmd.start = accept & req_tlast;
            if (accept && req_tlast) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.k_is_one) begin
               cmd.row_init = 1'b1;
               state_in     = status.more ? S_RD : S_WR;
            end else if (status.fit) begin
               cmd.eval = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_WR;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = status.more ? S_RD : S_WR;
         end
         S_WR: begin
            cmd.wr   = 1'b1;
            state_in = status.i_zero ? S_ERD : S_RD;
         end
         S_ERD: begin
            state_in = S_ELAT;
         end
         S_ELAT: begin
            cmd.elat = 1'b1;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (status.div_done) begin
               cmd.eload = 1'b1;
               state_in  = S_EOUT;
            end
         end
         S_EOUT: begin
            if (rsp_tready) begin
               cmd.enext = 1'b1;
               state_in  = status.last_line ? S_LOAD : S_ERD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/min_badness_line_breaker.sv
// input: one word per cycle while loading; after the last word the planner
// evaluates candidate lines word by word; a candidate line that overruns the width
// ends the row, one that fits passes the 8-step divider and two multiply stages
// output: one line held in the output register until the receiver takes it
// reset: synchronous, active high; clears the fsm, word count and overflow,
// line_width returns to 80
module min_badness_line_breaker #(
   parameter int MAX_WORDS = mblb_pkg::MaxWords
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mblb_pkg::ReqDataW-1:0]      req_tdata,  // word_length
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // first_word, word_count, narrow_gap, narrow_gap_count, total_cost, overflow
   output logic [mblb_pkg::RspDataW-1:0]      rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [mblb_pkg::LineW-1:0]         csr_wdata
);

   import mblb_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [LineW-1:0]   width_ff, width_in;

   assign width_in = csr_we ? csr_wdata : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= LineW'(LineWidthReset);
      end else begin
         width_ff <= width_in;
      end
   end

   mblb_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tlast(req_tlast), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd)
   );

   mblb_dp #(.MAX_WORDS(MAX_WORDS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .word_length(req_tdata[LenW-1:0]), .line_width(width_ff),
      .rsp_data(rsp_tdata), .rsp_last(rsp_tlast)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input ready while result pending");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:6] != 7'd0)) else $error("line with no words");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready) else $error("not ready after reset");

endmodule
